/* hdl/bmls_pkg.sv */
package bmls_pkg;

    localparam int DEPTH_W  = 20;
    localparam int LOAD_W   = 16;
    localparam int ID_W     = 16;
    localparam int REASON_W = 2;

    // sized for the largest supported server count (1024)
    localparam int CNT_W_MAX  = 11;
    localparam int ADDR_W_MAX = 10;

    localparam int CURSOR_W  = 64;
    localparam int DIGIT_W   = 4;
    localparam int DIV_STEPS = CURSOR_W / DIGIT_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [REASON_W-1:0] REASON_PREFIX = 2'd0;
    localparam logic [REASON_W-1:0] REASON_LOAD   = 2'd1;
    localparam logic [REASON_W-1:0] REASON_RR     = 2'd2;
    localparam logic [REASON_W-1:0] REASON_NONE   = 2'd3;

    typedef struct packed {
        logic [CNT_W_MAX-1:0] count;
        logic [DEPTH_W-1:0]   depth;
        logic                 bank;
    } summary_t;

    typedef struct packed {
        logic                  en;
        logic                  bank;
        logic [ADDR_W_MAX-1:0] addr;
        logic [ID_W-1:0]       id;
    } tie_wr_t;

endpackage

/* hdl/bmls_queue.sv */
module bmls_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bmls_pkg::summary_t push_data,
    output logic               ready,
    output bmls_pkg::summary_t head,
    input  logic               pop
);
    import bmls_pkg::*;

    summary_t   slot_reg [0:1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign ready = (fill_reg != 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> fill_reg != 2'd0)
        else $error("summary queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> fill_reg != 2'd2 || pop)
        else $error("summary queue pushed while full");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("summary queue fill count out of range");

endmodule

/* hdl/bmls_front.sv */
module bmls_front
#(
    parameter int MAX_SERVERS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               eligible,
    input  logic [19:0]        match_depth,
    input  logic [15:0]        in_flight,
    input  logic [15:0]        server_id,
    input  logic               last,
    output bmls_pkg::tie_wr_t  tie_wr,
    output logic               push,
    output bmls_pkg::summary_t push_data,
    input  logic               release_bank
);
    import bmls_pkg::*;

    localparam int CW = $clog2(MAX_SERVERS + 1);

    logic [DEPTH_W-1:0] best_depth_reg;
    logic [DEPTH_W-1:0] best_depth_next;
    logic [LOAD_W-1:0]  best_load_reg;
    logic [LOAD_W-1:0]  best_load_next;
    logic [CW-1:0]      tie_count_reg;
    logic [CW-1:0]      tie_count_next;
    logic               bank_reg;
    logic               bank_next;
    logic [1:0]         busy_reg;
    logic [1:0]         busy_next;

    logic               accept;
    logic               better;
    logic               equal;
    logic [DEPTH_W-1:0] depth_upd;
    logic [LOAD_W-1:0]  load_upd;
    logic [CW-1:0]      count_upd;

    // both tie banks held by sets still waiting for their pick
    assign in_stall = (busy_reg == 2'd2);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        better = (tie_count_reg == '0) || (match_depth > best_depth_reg) ||
                 (match_depth == best_depth_reg && in_flight < best_load_reg);
        equal  = (match_depth == best_depth_reg) && (in_flight == best_load_reg);

        depth_upd = best_depth_reg;
        load_upd  = best_load_reg;
        count_upd = tie_count_reg;
        tie_wr.en   = 1'b0;
        tie_wr.bank = bank_reg;
        tie_wr.addr = ADDR_W_MAX'(tie_count_reg);
        tie_wr.id   = server_id;

        if (accept && eligible)
        begin
            if (better)
            begin
                depth_upd   = match_depth;
                load_upd    = in_flight;
                count_upd   = CW'(1);
                tie_wr.en   = 1'b1;
                tie_wr.addr = '0;
            end
            else if (equal && tie_count_reg < CW'(MAX_SERVERS))
            begin
                count_upd = tie_count_reg + CW'(1);
                tie_wr.en = 1'b1;
            end
        end

        push            = accept && last;
        push_data.count = CNT_W_MAX'(count_upd);
        push_data.depth = depth_upd;
        push_data.bank  = bank_reg;

        if (push)
        begin
            best_depth_next = '0;
            best_load_next  = '0;
            tie_count_next  = '0;
            bank_next       = !bank_reg;
        end
        else
        begin
            best_depth_next = depth_upd;
            best_load_next  = load_upd;
            tie_count_next  = count_upd;
            bank_next       = bank_reg;
        end

        busy_next = busy_reg + {1'b0, push} - {1'b0, release_bank};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_depth_reg <= '0;
            best_load_reg  <= '0;
            tie_count_reg  <= '0;
            bank_reg       <= 1'b0;
            busy_reg       <= 2'd0;
        end
        else
        begin
            best_depth_reg <= best_depth_next;
            best_load_reg  <= best_load_next;
            tie_count_reg  <= tie_count_next;
            bank_reg       <= bank_next;
            busy_reg       <= busy_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tie_count_reg <= CW'(MAX_SERVERS))
        else $error("tie count beyond buffer size");

    a_release_owned: assert property (@(posedge clk) disable iff (!rst_n)
        release_bank |-> busy_reg != 2'd0)
        else $error("bank released with none held");

    a_empty_set_clear: assert property (@(posedge clk) disable iff (!rst_n)
        tie_count_reg == '0 |-> best_depth_reg == '0 && best_load_reg == '0)
        else $error("running best kept without any tie");

endmodule

/* hdl/bmls_back.sv */
module bmls_back
#(
    parameter int MAX_SERVERS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  bmls_pkg::tie_wr_t  tie_wr,
    input  logic               q_ready,
    input  bmls_pkg::summary_t q_head,
    output logic               q_pop,
    output logic               release_bank,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               found,
    output logic [15:0]        chosen_id,
    output logic [1:0]         reason,
    output logic [19:0]        chosen_depth
);
    import bmls_pkg::*;

    localparam int CW        = $clog2(MAX_SERVERS + 1);
    localparam int AW        = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int MEM_DEPTH = 2 ** (AW + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_LOAD = 2'd3;

    logic [ID_W-1:0]     tie_mem [0:MEM_DEPTH-1];
    logic [ID_W-1:0]     rd_data_reg;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_next;
    logic [DEPTH_W-1:0]  depth_reg;
    logic [DEPTH_W-1:0]  depth_next;
    logic                bank_reg;
    logic                bank_next;
    logic [AW-1:0]       rd_addr_reg;
    logic [AW-1:0]       rd_addr_next;
    logic [CW-1:0]       rem_reg;
    logic [CW-1:0]       rem_next;
    logic [CURSOR_W-1:0] shift_reg;
    logic [CURSOR_W-1:0] shift_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic [CURSOR_W-1:0] rr_cursor_reg;
    logic [CURSOR_W-1:0] rr_cursor_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic                found_reg;
    logic [ID_W-1:0]     chosen_id_reg;
    logic [REASON_W-1:0] reason_reg;
    logic [DEPTH_W-1:0]  chosen_depth_reg;

    logic                load_ok;
    logic                has_tie;
    logic [CW:0]         r;
    logic [DIGIT_W-1:0]  digit;

    always_ff @(posedge clk)
    begin
        if (tie_wr.en)
        begin
            tie_mem[{tie_wr.bank, tie_wr.addr[AW-1:0]}] <= tie_wr.id;
        end
        if (state_reg == S_READ)
        begin
            rd_data_reg <= tie_mem[{bank_reg, rd_addr_reg}];
        end
    end

    assign load_ok = (state_reg == S_LOAD) && (!out_valid_reg || !out_stall);
    assign has_tie = (cnt_reg > CW'(1));

    always_comb
    begin
        // remainder of the cursor by the tie count, one digit per cycle
        digit = shift_reg[CURSOR_W-1 -: DIGIT_W];
        r     = {1'b0, rem_reg};
        for (int i = 0; i < DIGIT_W; i++)
        begin
            r = {r[CW-1:0], digit[DIGIT_W-1-i]};
            if (r >= {1'b0, cnt_reg})
            begin
                r = r - {1'b0, cnt_reg};
            end
        end

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        depth_next     = depth_reg;
        bank_next      = bank_reg;
        rd_addr_next   = rd_addr_reg;
        rem_next       = rem_reg;
        shift_next     = shift_reg;
        step_next      = step_reg;
        rr_cursor_next = rr_cursor_reg;
        q_pop          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_ready)
                begin
                    q_pop        = 1'b1;
                    cnt_next     = q_head.count[CW-1:0];
                    depth_next   = q_head.depth;
                    bank_next    = q_head.bank;
                    rd_addr_next = '0;
                    rem_next     = '0;
                    shift_next   = rr_cursor_reg;
                    step_next    = STEP_W'(DIV_STEPS - 1);
                    if (q_head.count == '0)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (q_head.count == CNT_W_MAX'(1))
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                rem_next   = r[CW-1:0];
                shift_next = shift_reg << DIGIT_W;
                step_next  = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    rd_addr_next = r[AW-1:0];
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (load_ok)
                begin
                    if (has_tie)
                    begin
                        rr_cursor_next = rr_cursor_reg + CURSOR_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = (out_valid_reg && out_stall) || load_ok;
    end

    assign release_bank = load_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rr_cursor_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rr_cursor_reg <= rr_cursor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        depth_reg   <= depth_next;
        bank_reg    <= bank_next;
        rd_addr_reg <= rd_addr_next;
        rem_reg     <= rem_next;
        shift_reg   <= shift_next;
        step_reg    <= step_next;
        if (load_ok)
        begin
            found_reg <= (cnt_reg != '0);
            if (cnt_reg == '0)
            begin
                chosen_id_reg    <= '0;
                chosen_depth_reg <= '0;
                reason_reg       <= REASON_NONE;
            end
            else
            begin
                chosen_id_reg    <= rd_data_reg;
                chosen_depth_reg <= depth_reg;
                if (depth_reg != '0)
                begin
                    reason_reg <= REASON_PREFIX;
                end
                else if (has_tie)
                begin
                    reason_reg <= REASON_RR;
                end
                else
                begin
                    reason_reg <= REASON_LOAD;
                end
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign chosen_id    = chosen_id_reg;
    assign reason       = reason_reg;
    assign chosen_depth = chosen_depth_reg;

    a_rem_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < cnt_reg)
        else $error("remainder not below tie count");

    a_div_needs_tie: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cnt_reg > CW'(1))
        else $error("divide started without a tie");

    a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(load_ok && has_tie) |=> $stable(rr_cursor_reg))
        else $error("cursor moved without a round robin pick");

    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> {1'b0, rd_addr_reg} < (AW + 1)'(cnt_reg))
        else $error("tie read beyond recorded entries");

endmodule

/* hdl/best_match_least_load_selector.sv */
// input: one beat per cycle; stalls while both tie buffer banks hold sets awaiting a pick
// result: sets queue for the picker; no winner: load output; one winner: read ties, load;
// with a tie: cursor remainder (4 bits a cycle), read, load; picker takes one set at a time
// reset: asynchronous, clears the running best, tie count, queue, cursor and output valid
// tie id buffer is not cleared; only entries written in the current set are read
module best_match_least_load_selector
#(
    parameter int MAX_SERVERS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        eligible,
    input  logic [19:0] match_depth,
    input  logic [15:0] in_flight,
    input  logic [15:0] server_id,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [15:0] chosen_id,
    output logic [1:0]  reason,
    output logic [19:0] chosen_depth
);
    import bmls_pkg::*;

    tie_wr_t  tie_wr;
    summary_t push_data;
    summary_t q_head;
    logic     push;
    logic     q_ready;
    logic     q_pop;
    logic     release_bank;

    bmls_front #(
        .MAX_SERVERS (MAX_SERVERS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .eligible     (eligible),
        .match_depth  (match_depth),
        .in_flight    (in_flight),
        .server_id    (server_id),
        .last         (last),
        .tie_wr       (tie_wr),
        .push         (push),
        .push_data    (push_data),
        .release_bank (release_bank)
    );

    bmls_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .ready     (q_ready),
        .head      (q_head),
        .pop       (q_pop)
    );

    bmls_back #(
        .MAX_SERVERS (MAX_SERVERS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tie_wr       (tie_wr),
        .q_ready      (q_ready),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .release_bank (release_bank),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .chosen_id    (chosen_id),
        .reason       (reason),
        .chosen_depth (chosen_depth)
    );

endmodule
